/* rtl/tsod_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsod_pkg
// Shared types and constants for the two-state ODE derivative pipeline:
// mode and status codes, register indexes, fixed-point positions, latencies.
// ----------------------------------------------------------------------------
package tsod_pkg;

    // Fixed-point positions: rates and compartments Q8.24, ages Q8.16
    localparam int FRAC_BITS = 24;
    localparam int AGE_FRAC  = 16;

    // Rates handled per item: incidence, remission, excess and other mortality
    localparam int NUM_RATES = 4;

    // Pipeline depth of the numerator stages and the fixed part of the divider
    localparam int NUM_LAT   = 4;
    localparam int DIV_EXTRA = 2;

    // Configuration register indexes
    localparam int REG_INDEX_WIDTH = 3;
    localparam logic [REG_INDEX_WIDTH-1:0] REG_AGE_BOUNDS = 3'd0;
    localparam logic [REG_INDEX_WIDTH-1:0] REG_INCIDENCE  = 3'd1;
    localparam logic [REG_INDEX_WIDTH-1:0] REG_REMISSION  = 3'd2;
    localparam logic [REG_INDEX_WIDTH-1:0] REG_EXCESS     = 3'd3;
    localparam logic [REG_INDEX_WIDTH-1:0] REG_OTHER      = 3'd4;

    // Evaluation modes
    typedef enum logic [1:0] {
        FUNC_DERIV = 2'd0,
        FUNC_SLOPE = 2'd1,
        FUNC_JACOB = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    // Control that travels alongside each transaction
    typedef struct packed {
        logic    valid;
        func_t   func;
        status_t status;
    } ctl_t;

endpackage

/* rtl/tsod_numer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsod_numer
// Numerator stages for one rate lane: forms the interpolation numerator or
// the age-slope numerator, takes its magnitude and builds the rounding
// dividend 2|num|+d and divisor 2d for the divider. Four register stages.
// ----------------------------------------------------------------------------
module tsod_numer #(
    parameter int DATA_WIDTH = 32,
    parameter int AGE_WIDTH  = 24
) (
    input  logic                                 clk,
    input  tsod_pkg::func_t                      func_in,
    input  logic [AGE_WIDTH-1:0]                 ha,
    input  logic [AGE_WIDTH-1:0]                 al,
    input  logic [AGE_WIDTH-1:0]                 d,
    input  logic signed [DATA_WIDTH-1:0]         r0,
    input  logic signed [DATA_WIDTH-1:0]         r1,
    output logic [DATA_WIDTH+AGE_WIDTH+2:0]      n,
    output logic [AGE_WIDTH:0]                   dd,
    output logic                                 neg
);
    import tsod_pkg::*;

    localparam int PW   = DATA_WIDTH + AGE_WIDTH + 1;
    localparam int NUMW = DATA_WIDTH + AGE_WIDTH + 2;
    localparam int NW   = NUMW + 1;

    // Stage 2: products and end-point difference
    logic signed [PW-1:0]         p0_next, p1_next;
    logic signed [DATA_WIDTH:0]   diff_next;
    logic signed [PW-1:0]         p0_reg, p1_reg;
    logic signed [DATA_WIDTH:0]   diff_reg;
    func_t                        func2_reg;
    logic [AGE_WIDTH-1:0]         d2_reg;

    // Stage 3: selected numerator
    logic signed [NUMW-1:0]       sum_num;
    logic [NUMW-1:0]              slope_num;
    logic [NUMW-1:0]              num_next, num_reg;
    logic [AGE_WIDTH-1:0]         d3_reg;

    // Stage 4: sign and magnitude
    logic                         neg4_next, neg4_reg;
    logic [NUMW-1:0]              mag_next, mag_reg;
    logic [AGE_WIDTH-1:0]         d4_reg;

    // Stage 5: dividend and divisor
    logic [NW-1:0]                n_next, n_reg;
    logic [AGE_WIDTH:0]           dd_next, dd_reg;
    logic                         neg5_reg;

    // Weight each end-point rate by the distance from the age to the other end
    always_comb
    begin
        p0_next   = r0 * $signed({1'b0, ha});
        p1_next   = r1 * $signed({1'b0, al});
        diff_next = r1 - r0;
    end

    // Pick the interpolation sum or the scaled difference
    always_comb
    begin
        sum_num   = p0_reg + p1_reg;
        slope_num = {{(NUMW-DATA_WIDTH-1){diff_reg[DATA_WIDTH]}}, diff_reg} << AGE_FRAC;
        num_next  = (func2_reg == FUNC_SLOPE) ? slope_num : sum_num;
    end

    // Split into sign and magnitude
    always_comb
    begin
        neg4_next = num_reg[NUMW-1];
        mag_next  = neg4_next ? (~num_reg + NUMW'(1)) : num_reg;
    end

    // Bias by half the divisor for round to nearest
    always_comb
    begin
        n_next  = {mag_reg, 1'b0} + NW'(d4_reg);
        dd_next = {d4_reg, 1'b0};
    end

    // Advance the stages
    always_ff @(posedge clk)
    begin
        p0_reg    <= p0_next;
        p1_reg    <= p1_next;
        diff_reg  <= diff_next;
        func2_reg <= func_in;
        d2_reg    <= d;

        num_reg   <= num_next;
        d3_reg    <= d2_reg;

        neg4_reg  <= neg4_next;
        mag_reg   <= mag_next;
        d4_reg    <= d3_reg;

        n_reg     <= n_next;
        dd_reg    <= dd_next;
        neg5_reg  <= neg4_reg;
    end

    assign n   = n_reg;
    assign dd  = dd_reg;
    assign neg = neg5_reg;

endmodule

/* rtl/tsod_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsod_div
// Pipelined restoring divider for one rate lane, one quotient bit per stage.
// Detects quotient overflow up front, restores the sign at the end and
// saturates to the signed data range in a final output register.
// ----------------------------------------------------------------------------
module tsod_div #(
    parameter int DATA_WIDTH = 32,
    parameter int AGE_WIDTH  = 24
) (
    input  logic                                 clk,
    input  logic [DATA_WIDTH+AGE_WIDTH+2:0]      n,
    input  logic [AGE_WIDTH:0]                   dd,
    input  logic                                 neg,
    output logic signed [DATA_WIDTH-1:0]         rate
);
    import tsod_pkg::*;

    localparam int NW = DATA_WIDTH + AGE_WIDTH + 3;
    localparam int HW = NW - DATA_WIDTH;
    localparam int RW = AGE_WIDTH + 1;

    localparam logic signed [DATA_WIDTH-1:0] MAXV = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] MINV = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic [HW-1:0]          nh;
    logic                   ovf0;

    logic [RW-1:0]          rem_reg [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0]  low_reg [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0]  q_reg   [DATA_WIDTH+1];
    logic                   ovf_reg [DATA_WIDTH+1];
    logic                   neg_reg [DATA_WIDTH+1];
    logic [RW-1:0]          dd_reg  [DATA_WIDTH+1];

    logic [DATA_WIDTH-1:0]  q_fin;
    logic                   big;
    logic signed [DATA_WIDTH-1:0] rate_next, rate_reg;

    // Flag a quotient too wide for the data range; seed the remainder
    always_comb
    begin
        nh   = n[NW-1:DATA_WIDTH];
        ovf0 = (nh >= HW'(dd));
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= nh[RW-1:0];
        low_reg[0] <= n[DATA_WIDTH-1:0];
        q_reg[0]   <= '0;
        ovf_reg[0] <= ovf0;
        neg_reg[0] <= neg;
        dd_reg[0]  <= dd;
    end

    // One quotient bit per stage, most significant first
    for (genvar k = 1; k <= DATA_WIDTH; k++)
    begin : g_step
        logic [RW:0]   shifted;
        logic [RW+1:0] trial;
        logic          take;
        logic [RW-1:0] rem_next;

        always_comb
        begin
            shifted  = {rem_reg[k-1], low_reg[k-1][DATA_WIDTH-1]};
            trial    = {1'b0, shifted} - {2'b00, dd_reg[k-1]};
            take     = ~trial[RW+1];
            rem_next = take ? trial[RW-1:0] : shifted[RW-1:0];
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= rem_next;
            low_reg[k] <= low_reg[k-1] << 1;
            q_reg[k]   <= {q_reg[k-1][DATA_WIDTH-2:0], take};
            ovf_reg[k] <= ovf_reg[k-1];
            neg_reg[k] <= neg_reg[k-1];
            dd_reg[k]  <= dd_reg[k-1];
        end
    end

    // Restore the sign and clamp to the data range
    always_comb
    begin
        q_fin = q_reg[DATA_WIDTH];
        if (neg_reg[DATA_WIDTH])
        begin
            big       = ovf_reg[DATA_WIDTH] ||
                        (q_fin[DATA_WIDTH-1] && (|q_fin[DATA_WIDTH-2:0]));
            rate_next = big ? MINV : $signed(~q_fin + DATA_WIDTH'(1));
        end
        else
        begin
            big       = ovf_reg[DATA_WIDTH] || q_fin[DATA_WIDTH-1];
            rate_next = big ? MAXV : $signed(q_fin);
        end
    end

    always_ff @(posedge clk)
    begin
        rate_reg <= rate_next;
    end

    assign rate = rate_reg;

endmodule

/* rtl/tsod_combine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsod_combine
// Combines the four rates with S and C: products, exact sums, round half up
// to Q8.24, saturation, Jacobian entries and the final mode and status
// selection into the output registers. Three register stages.
// ----------------------------------------------------------------------------
module tsod_combine #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tsod_pkg::ctl_t                ctl_in,
    input  logic signed [DATA_WIDTH-1:0]  s_in,
    input  logic signed [DATA_WIDTH-1:0]  c_in,
    input  logic signed [DATA_WIDTH-1:0]  iota,
    input  logic signed [DATA_WIDTH-1:0]  rho,
    input  logic signed [DATA_WIDTH-1:0]  chi,
    input  logic signed [DATA_WIDTH-1:0]  omega,
    output logic                          done,
    output logic signed [DATA_WIDTH-1:0]  res_a,
    output logic signed [DATA_WIDTH-1:0]  res_b,
    output logic signed [DATA_WIDTH-1:0]  res_c,
    output logic signed [DATA_WIDTH-1:0]  res_d,
    output logic [1:0]                    status
);
    import tsod_pkg::*;

    localparam int PW   = 2 * DATA_WIDTH;
    localparam int SUMW = 2 * DATA_WIDTH + 2;
    localparam int JW   = DATA_WIDTH + 2;

    localparam logic signed [SUMW-1:0] HALF     = SUMW'(1) << (FRAC_BITS - 1);
    localparam logic signed [SUMW-1:0] SUM_MAX  = (SUMW'(1) << (DATA_WIDTH - 1)) - SUMW'(1);
    localparam logic signed [SUMW-1:0] SUM_MIN  = -(SUMW'(1) << (DATA_WIDTH - 1));
    localparam logic signed [JW-1:0]   JAC_MAX  = (JW'(1) << (DATA_WIDTH - 1)) - JW'(1);
    localparam logic signed [JW-1:0]   JAC_MIN  = -(JW'(1) << (DATA_WIDTH - 1));

    function automatic logic signed [DATA_WIDTH-1:0] sat_sum(input logic signed [SUMW-1:0] v);
        logic signed [DATA_WIDTH-1:0] r;
        if (v > SUM_MAX)
            r = SUM_MAX[DATA_WIDTH-1:0];
        else if (v < SUM_MIN)
            r = SUM_MIN[DATA_WIDTH-1:0];
        else
            r = v[DATA_WIDTH-1:0];
        return r;
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] sat_jac(input logic signed [JW-1:0] v);
        logic signed [DATA_WIDTH-1:0] r;
        if (v > JAC_MAX)
            r = JAC_MAX[DATA_WIDTH-1:0];
        else if (v < JAC_MIN)
            r = JAC_MIN[DATA_WIDTH-1:0];
        else
            r = v[DATA_WIDTH-1:0];
        return r;
    endfunction

    // Stage 1: products and Jacobian sums
    ctl_t                          ctl1_reg;
    logic signed [PW-1:0]          is_next, os_next, rc_next, oc_next, xc_next;
    logic signed [PW-1:0]          is_reg, os_reg, rc_reg, oc_reg, xc_reg;
    logic signed [JW-1:0]          j0_next, j3_next, j0_reg, j3_reg;
    logic signed [DATA_WIDTH-1:0]  rho1_reg, iota1_reg;

    // Stage 2: exact sums and clamped Jacobian
    ctl_t                          ctl2_reg;
    logic signed [SUMW-1:0]        ds_next, dc_next, ds_reg, dc_reg;
    logic signed [DATA_WIDTH-1:0]  j0s_reg, j3s_reg, rho2_reg, iota2_reg;

    // Stage 3: output registers
    logic signed [SUMW-1:0]        ds_rnd, dc_rnd;
    logic signed [DATA_WIDTH-1:0]  a_next, b_next, c_next, d_next;
    logic                          done_reg;
    logic signed [DATA_WIDTH-1:0]  res_a_reg, res_b_reg, res_c_reg, res_d_reg;
    status_t                       status_reg;

    // Form the rate products and negated rate sums
    always_comb
    begin
        is_next = iota * s_in;
        os_next = omega * s_in;
        rc_next = rho * c_in;
        oc_next = omega * c_in;
        xc_next = chi * c_in;
        j0_next = -iota - omega;
        j3_next = -rho - omega - chi;
    end

    // Sum the products for dS and dC
    always_comb
    begin
        ds_next = rc_reg - is_reg - os_reg;
        dc_next = is_reg - rc_reg - oc_reg - xc_reg;
    end

    // Round, clamp and select by mode; drop values on a bad status
    always_comb
    begin
        ds_rnd = (ds_reg + HALF) >>> FRAC_BITS;
        dc_rnd = (dc_reg + HALF) >>> FRAC_BITS;
        a_next = '0;
        b_next = '0;
        c_next = '0;
        d_next = '0;
        if (ctl2_reg.status == STATUS_OK)
        begin
            case (ctl2_reg.func)
                FUNC_DERIV, FUNC_SLOPE:
                begin
                    a_next = sat_sum(ds_rnd);
                    b_next = sat_sum(dc_rnd);
                end
                FUNC_JACOB:
                begin
                    a_next = j0s_reg;
                    b_next = rho2_reg;
                    c_next = iota2_reg;
                    d_next = j3s_reg;
                end
                default:
                begin
                    a_next = '0;
                end
            endcase
        end
    end

    // Advance control with reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ctl1_reg <= ctl_in;
            ctl2_reg <= ctl1_reg;
            done_reg <= ctl2_reg.valid;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        is_reg     <= is_next;
        os_reg     <= os_next;
        rc_reg     <= rc_next;
        oc_reg     <= oc_next;
        xc_reg     <= xc_next;
        j0_reg     <= j0_next;
        j3_reg     <= j3_next;
        rho1_reg   <= rho;
        iota1_reg  <= iota;

        ds_reg     <= ds_next;
        dc_reg     <= dc_next;
        j0s_reg    <= sat_jac(j0_reg);
        j3s_reg    <= sat_jac(j3_reg);
        rho2_reg   <= rho1_reg;
        iota2_reg  <= iota1_reg;

        res_a_reg  <= a_next;
        res_b_reg  <= b_next;
        res_c_reg  <= c_next;
        res_d_reg  <= d_next;
        status_reg <= ctl2_reg.status;
    end

    assign done   = done_reg;
    assign res_a  = res_a_reg;
    assign res_b  = res_b_reg;
    assign res_c  = res_c_reg;
    assign res_d  = res_d_reg;
    assign status = status_reg;

endmodule

/* rtl/two_state_ode_derivative.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_state_ode_derivative
// Two-compartment ODE kernel: interpolates four rates at an age inside a
// configured interval and returns derivatives, age partials or Jacobian.
//
//   channel   handshake            payload
//   -------   ------------------   ------------------------------------------
//   input     start & !busy        func, age, s_value, c_value
//   result    done (one cycle)     res_a, res_b, res_c, res_d, status
//   config    cfg_wr_en            cfg_index, cfg_data
//
// One transaction is taken every cycle; busy stays low.
// Each transaction passes the entry stage, the numerator stages, the divider
// resolving one quotient bit per stage in all four rate lanes, then tsod_combine.
// Reset clears the configuration registers to zero and all valid bits.
// The receiver cannot stall: each result shows on done for one cycle only.
// ----------------------------------------------------------------------------
module two_state_ode_derivative #(
    parameter int DATA_WIDTH = 32,
    parameter int AGE_WIDTH  = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          func,
    input  logic [AGE_WIDTH-1:0]                age,
    input  logic signed [DATA_WIDTH-1:0]        s_value,
    input  logic signed [DATA_WIDTH-1:0]        c_value,
    input  logic                                cfg_wr_en,
    input  logic [tsod_pkg::REG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [((2*AGE_WIDTH > 2*DATA_WIDTH) ? 2*AGE_WIDTH : 2*DATA_WIDTH)-1:0] cfg_data,
    output logic                                done,
    output logic signed [DATA_WIDTH-1:0]        res_a,
    output logic signed [DATA_WIDTH-1:0]        res_b,
    output logic signed [DATA_WIDTH-1:0]        res_c,
    output logic signed [DATA_WIDTH-1:0]        res_d,
    output logic [1:0]                          status
);
    import tsod_pkg::*;

    localparam int NW  = DATA_WIDTH + AGE_WIDTH + 3;
    localparam int LAT = NUM_LAT + DATA_WIDTH + DIV_EXTRA;

    // Configuration registers
    logic [2*AGE_WIDTH-1:0]   age_bounds_reg;
    logic [2*DATA_WIDTH-1:0]  rate_pair_reg [NUM_RATES];

    // Entry stage
    logic [AGE_WIDTH-1:0]     lo, hi;
    ctl_t                     ctl_f1_next, ctl_f1_reg;
    logic [AGE_WIDTH-1:0]     ha_f1_reg, al_f1_reg, d_f1_reg;
    logic signed [DATA_WIDTH-1:0] s_f1_reg, c_f1_reg;

    // Side delay line matching the rate lanes
    ctl_t                     ctl_dly_reg [LAT];
    logic signed [DATA_WIDTH-1:0] s_dly_reg [LAT];
    logic signed [DATA_WIDTH-1:0] c_dly_reg [LAT];

    // Rate lanes
    logic [NW-1:0]            n_lane    [NUM_RATES];
    logic [AGE_WIDTH:0]       dd_lane   [NUM_RATES];
    logic                     neg_lane  [NUM_RATES];
    logic signed [DATA_WIDTH-1:0] rate_lane [NUM_RATES];

    assign busy = 1'b0;

    // Hold configuration; ignore writes beyond the register list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            age_bounds_reg <= '0;
            for (int k = 0; k < NUM_RATES; k++)
            begin
                rate_pair_reg[k] <= '0;
            end
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_AGE_BOUNDS: age_bounds_reg   <= cfg_data[2*AGE_WIDTH-1:0];
                REG_INCIDENCE:  rate_pair_reg[0] <= cfg_data[2*DATA_WIDTH-1:0];
                REG_REMISSION:  rate_pair_reg[1] <= cfg_data[2*DATA_WIDTH-1:0];
                REG_EXCESS:     rate_pair_reg[2] <= cfg_data[2*DATA_WIDTH-1:0];
                REG_OTHER:      rate_pair_reg[3] <= cfg_data[2*DATA_WIDTH-1:0];
                default:        age_bounds_reg   <= age_bounds_reg;
            endcase
        end
    end

    // Classify the age against the interval
    always_comb
    begin
        lo = age_bounds_reg[AGE_WIDTH-1:0];
        hi = age_bounds_reg[2*AGE_WIDTH-1:AGE_WIDTH];
        ctl_f1_next.valid = start & ~busy;
        ctl_f1_next.func  = func_t'(func);
        if (hi <= lo)
            ctl_f1_next.status = STATUS_EMPTY;
        else if ((age < lo) || (age > hi))
            ctl_f1_next.status = STATUS_RANGE;
        else
            ctl_f1_next.status = STATUS_OK;
    end

    // Advance control through the entry stage and the delay line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_f1_reg <= '0;
            for (int k = 0; k < LAT; k++)
            begin
                ctl_dly_reg[k] <= '0;
            end
        end
        else
        begin
            ctl_f1_reg     <= ctl_f1_next;
            ctl_dly_reg[0] <= ctl_f1_reg;
            for (int k = 1; k < LAT; k++)
            begin
                ctl_dly_reg[k] <= ctl_dly_reg[k-1];
            end
        end
    end

    // Advance payload through the entry stage and the delay line
    always_ff @(posedge clk)
    begin
        ha_f1_reg    <= hi - age;
        al_f1_reg    <= age - lo;
        d_f1_reg     <= hi - lo;
        s_f1_reg     <= s_value;
        c_f1_reg     <= c_value;
        s_dly_reg[0] <= s_f1_reg;
        c_dly_reg[0] <= c_f1_reg;
        for (int k = 1; k < LAT; k++)
        begin
            s_dly_reg[k] <= s_dly_reg[k-1];
            c_dly_reg[k] <= c_dly_reg[k-1];
        end
    end

    // One numerator and divider per rate
    for (genvar k = 0; k < NUM_RATES; k++)
    begin : g_lane
        tsod_numer #(
            .DATA_WIDTH (DATA_WIDTH),
            .AGE_WIDTH  (AGE_WIDTH)
        ) u_numer (
            .clk     (clk),
            .func_in (ctl_f1_reg.func),
            .ha      (ha_f1_reg),
            .al      (al_f1_reg),
            .d       (d_f1_reg),
            .r0      ($signed(rate_pair_reg[k][DATA_WIDTH-1:0])),
            .r1      ($signed(rate_pair_reg[k][2*DATA_WIDTH-1:DATA_WIDTH])),
            .n       (n_lane[k]),
            .dd      (dd_lane[k]),
            .neg     (neg_lane[k])
        );

        tsod_div #(
            .DATA_WIDTH (DATA_WIDTH),
            .AGE_WIDTH  (AGE_WIDTH)
        ) u_div (
            .clk  (clk),
            .n    (n_lane[k]),
            .dd   (dd_lane[k]),
            .neg  (neg_lane[k]),
            .rate (rate_lane[k])
        );
    end

    // Combine rates with the compartments
    tsod_combine #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_combine (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl_in (ctl_dly_reg[LAT-1]),
        .s_in   (s_dly_reg[LAT-1]),
        .c_in   (c_dly_reg[LAT-1]),
        .iota   (rate_lane[0]),
        .rho    (rate_lane[1]),
        .chi    (rate_lane[2]),
        .omega  (rate_lane[3]),
        .done   (done),
        .res_a  (res_a),
        .res_b  (res_b),
        .res_c  (res_c),
        .res_d  (res_d),
        .status (status)
    );

endmodule

/* tb/two_state_ode_derivative_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_state_ode_derivative_tb
// Self-checking bench for the two-state ODE kernel. A local predictor holds
// its own copy of the interval and rate registers. It interpolates the four
// rates and forms derivatives, age partials and Jacobian entries in exact
// wide arithmetic. Directed tests cover reset state, interval edges,
// empty intervals, saturation and unmapped register writes. Random traffic
// then runs under several sender idle patterns, and the interval and rates
// are reloaded every few dozen transactions.
// ----------------------------------------------------------------------------
module two_state_ode_derivative_tb;

    import tsod_pkg::*;

    localparam int DATA_W       = 32;
    localparam int AGE_W        = 24;
    localparam int PIPE_LATENCY = DATA_W + 10;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int CONFIG_SPAN  = 50;

    localparam logic signed [71:0] Q24_MAX = 72'sd2147483647;
    localparam logic signed [71:0] Q24_MIN = -72'sd2147483648;
    localparam logic signed [71:0] Q24_HALF = 72'sd8388608;

    // Expected result of one transaction
    typedef struct packed {
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] c;
        logic [DATA_W-1:0] d;
        status_t           st;
    } kernel_result_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    logic                  busy;
    logic [1:0]            func      = FUNC_DERIV;
    logic [AGE_W-1:0]      age       = '0;
    logic signed [DATA_W-1:0] s_value = '0;
    logic signed [DATA_W-1:0] c_value = '0;
    logic                  cfg_wr_en = 1'b0;
    logic [REG_INDEX_WIDTH-1:0] cfg_index = REG_AGE_BOUNDS;
    logic [63:0]           cfg_data  = '0;
    logic                  done;
    logic signed [DATA_W-1:0] res_a;
    logic signed [DATA_W-1:0] res_b;
    logic signed [DATA_W-1:0] res_c;
    logic signed [DATA_W-1:0] res_d;
    logic [1:0]            status;

    // Shadow of the configuration registers
    logic [2*AGE_W-1:0]    cfg_bounds = '0;
    logic [63:0]           cfg_rates [NUM_RATES];

    kernel_result_t        pending_results [$];
    int                    error_count = 0;
    int                    cycle_count = 0;

    two_state_ode_derivative #(
        .DATA_WIDTH (DATA_W),
        .AGE_WIDTH  (AGE_W)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .func      (func),
        .age       (age),
        .s_value   (s_value),
        .c_value   (c_value),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .res_a     (res_a),
        .res_b     (res_b),
        .res_c     (res_c),
        .res_d     (res_d),
        .status    (status)
    );

    // Clock: 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Abort on a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Divide rounding to nearest, ties away from zero; den > 0
    function automatic longint round_div(input longint num, input longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q   = (2 * mag + den) / (2 * den);
        return (num < 0) ? -q : q;
    endfunction

    function automatic logic signed [DATA_W-1:0] clamp_q24(input logic signed [71:0] x);
        if (x > Q24_MAX)
            return 32'sh7FFFFFFF;
        else if (x < Q24_MIN)
            return 32'sh80000000;
        return x[DATA_W-1:0];
    endfunction

    function automatic kernel_result_t eval_kernel(input func_t f, input logic [AGE_W-1:0] a_in,
                                                   input logic [DATA_W-1:0] s_in,
                                                   input logic [DATA_W-1:0] c_in);
        kernel_result_t    r;
        longint            lo_l;
        longint            hi_l;
        longint            age_l;
        longint            span;
        longint            s_l;
        longint            c_l;
        longint            r0;
        longint            r1;
        longint            rate [NUM_RATES];
        logic signed [71:0] sum_s;
        logic signed [71:0] sum_c;
        r     = '0;
        lo_l  = {40'd0, cfg_bounds[AGE_W-1:0]};
        hi_l  = {40'd0, cfg_bounds[2*AGE_W-1:AGE_W]};
        age_l = {40'd0, a_in};
        s_l   = longint'($signed(s_in));
        c_l   = longint'($signed(c_in));

        // Empty interval wins over an age outside it
        if (hi_l <= lo_l)
            r.st = STATUS_EMPTY;
        else if (age_l < lo_l || age_l > hi_l)
            r.st = STATUS_RANGE;
        else
            r.st = STATUS_OK;

        if (r.st == STATUS_OK && f != FUNC_NONE)
        begin
            span = hi_l - lo_l;
            // Interpolate each rate, or take its slope in age
            for (int k = 0; k < NUM_RATES; k++)
            begin
                r0 = longint'($signed(cfg_rates[k][31:0]));
                r1 = longint'($signed(cfg_rates[k][63:32]));
                if (f == FUNC_SLOPE)
                    rate[k] = clamp_q24(round_div((r1 - r0) * (longint'(1) << AGE_FRAC), span));
                else
                    rate[k] = round_div(r0 * (hi_l - age_l) + r1 * (age_l - lo_l), span);
            end
            // rate[0] iota, rate[1] rho, rate[2] chi, rate[3] omega
            if (f == FUNC_JACOB)
            begin
                r.a = clamp_q24(-(rate[0] + rate[3]));
                r.b = clamp_q24(rate[1]);
                r.c = clamp_q24(rate[0]);
                r.d = clamp_q24(-(rate[1] + rate[3] + rate[2]));
            end
            else
            begin
                sum_s = rate[1] * c_l - rate[0] * s_l - rate[3] * s_l;
                sum_c = rate[0] * s_l - rate[1] * c_l - rate[3] * c_l - rate[2] * c_l;
                r.a   = clamp_q24((sum_s + Q24_HALF) >>> FRAC_BITS);
                r.b   = clamp_q24((sum_c + Q24_HALF) >>> FRAC_BITS);
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input logic [DATA_W-1:0] exp_v,
                               input logic [DATA_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    // Compare each strobed result with the oldest outstanding transaction
    always @(posedge clk)
    begin : result_check
        kernel_result_t exp_r;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with no transaction outstanding: %h %h %h %h status %0d",
                         $time, res_a, res_b, res_c, res_d, status);
                error_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                check_field("res_a", exp_r.a, res_a);
                check_field("res_b", exp_r.b, res_b);
                check_field("res_c", exp_r.c, res_c);
                check_field("res_d", exp_r.d, res_d);
                check_field("status", {30'd0, exp_r.st}, {30'd0, status});
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Hold start high after acceptance; the caller drops it when idling
    task automatic send_item(input func_t f, input logic [AGE_W-1:0] a_in,
                             input logic [DATA_W-1:0] s_in, input logic [DATA_W-1:0] c_in,
                             input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        func    <= f;
        age     <= a_in;
        s_value <= s_in;
        c_value <= c_in;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(eval_kernel(f, a_in, s_in, c_in));
    endtask

    // Drop start and wait until every transaction has returned
    task automatic finish_batch();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Keep the write enable high; the caller drops it after the last write
    task automatic write_reg(input logic [REG_INDEX_WIDTH-1:0] idx, input logic [63:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        if (idx == REG_AGE_BOUNDS)
            cfg_bounds = data[2*AGE_W-1:0];
        else if (idx <= REG_OTHER)
            cfg_rates[idx - REG_INCIDENCE] = data;
    endtask

    task automatic load_config(input logic [AGE_W-1:0] lo, input logic [AGE_W-1:0] hi,
                               input logic [63:0] iota, input logic [63:0] rho,
                               input logic [63:0] chi, input logic [63:0] omega);
        // Bits above the two bounds are don't-care; toggle them anyway
        write_reg(REG_AGE_BOUNDS, {16'($urandom), hi, lo});
        write_reg(REG_INCIDENCE, iota);
        write_reg(REG_REMISSION, rho);
        write_reg(REG_EXCESS, chi);
        write_reg(REG_OTHER, omega);
        cfg_wr_en <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Random generators
    // ------------------------------------------------------------------

    function automatic int pick_gap(input int idle_pct);
        int n;
        n = 0;
        while (n < 20 && $urandom_range(99) < idle_pct)
            n++;
        return n;
    endfunction

    function automatic logic [DATA_W-1:0] random_rate();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return $urandom_range(32'h01000000, 0);
            5, 6:          return -$urandom_range(32'h00400000, 0);
            7:             return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
            default:       return $urandom;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] random_value();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return $urandom_range(32'h01000000, 0);
            5:             return -$urandom_range(32'h01000000, 0);
            default:       return $urandom;
        endcase
    endfunction

    function automatic func_t random_func();
        int unsigned pick;
        pick = $urandom_range(19);
        if (pick == 0)
            return FUNC_NONE;
        return func_t'(pick % 3);
    endfunction

    // Mostly inside the interval, with edges, outside ages and full-range noise
    function automatic logic [AGE_W-1:0] random_age();
        logic [AGE_W-1:0] lo;
        logic [AGE_W-1:0] hi;
        int unsigned      pick;
        lo   = cfg_bounds[AGE_W-1:0];
        hi   = cfg_bounds[2*AGE_W-1:AGE_W];
        pick = $urandom_range(19);
        if (hi > lo && pick < 2)
            return (pick == 0) ? lo : hi;
        if (hi > lo && pick < 17)
            return AGE_W'($urandom_range(hi, lo));
        if (pick < 19 && lo > 0)
            return AGE_W'($urandom_range(lo - 1, 0));
        if (pick < 19 && hi < 24'hFFFFFF)
            return AGE_W'($urandom_range(24'hFFFFFF, hi + 1));
        return AGE_W'($urandom);
    endfunction

    task automatic randomize_config();
        logic [AGE_W-1:0] lo;
        logic [AGE_W-1:0] hi;
        case ($urandom_range(9))
            0:
            begin
                // empty interval: end at or below start
                lo = AGE_W'($urandom);
                hi = AGE_W'($urandom_range(lo, 0));
            end
            1:
            begin
                lo = '0;
                hi = '1;
            end
            2:
            begin
                lo = AGE_W'($urandom_range(24'hFFFFFE));
                hi = lo + 1'b1;
            end
            default:
            begin
                lo = AGE_W'($urandom_range(24'h7FFFFF));
                hi = lo + AGE_W'($urandom_range(1) ? $urandom_range(24'hFFFF, 1)
                                                   : $urandom_range(24'h7FFFFF, 1));
            end
        endcase
        load_config(lo, hi, {random_rate(), random_rate()}, {random_rate(), random_rate()},
                    {random_rate(), random_rate()}, {random_rate(), random_rate()});
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // All registers clear after reset, so every mode reports an empty interval
    task automatic test_reset_state();
        send_item(FUNC_DERIV, 24'h010000, 32'h01000000, 32'h00800000, 0);
        send_item(FUNC_SLOPE, 24'h000000, 32'hFFFFFFFF, 32'h00000001, 0);
        send_item(FUNC_JACOB, 24'hFFFFFF, 32'h7FFFFFFF, 32'h80000000, 0);
        send_item(FUNC_NONE, 24'h123456, 32'h00000000, 32'h00000000, 0);
        finish_batch();
    endtask

    // Realistic rates; ages at and just past both interval ends, extreme S and C
    task automatic test_interval_edges();
        load_config(24'h010000, 24'h0A8000,
                    {32'h000CCCCD, 32'h00028F5C}, {32'h00051EB8, 32'h0019999A},
                    {32'h01800000, 32'h00800000}, {32'h00333333, 32'h00004189});
        send_item(FUNC_DERIV, 24'h010000, 32'h01000000, 32'h00800000, 0);
        send_item(FUNC_SLOPE, 24'h010000, 32'h01000000, 32'h00800000, 0);
        send_item(FUNC_JACOB, 24'h010000, 32'h01000000, 32'h00800000, 0);
        send_item(FUNC_NONE, 24'h054321, 32'h01000000, 32'h00800000, 1);
        send_item(FUNC_DERIV, 24'h0A8000, 32'h00C00000, 32'h00400000, 0);
        send_item(FUNC_JACOB, 24'h0A8000, 32'h00C00000, 32'h00400000, 0);
        send_item(FUNC_DERIV, 24'h00FFFF, 32'h01000000, 32'h00800000, 2);
        send_item(FUNC_SLOPE, 24'h0A8001, 32'h01000000, 32'h00800000, 0);
        send_item(FUNC_DERIV, 24'h000000, 32'h01000000, 32'h00800000, 0);
        send_item(FUNC_JACOB, 24'hFFFFFF, 32'h01000000, 32'h00800000, 0);
        send_item(FUNC_DERIV, 24'h054321, 32'h7FFFFFFF, 32'h80000000, 0);
        send_item(FUNC_SLOPE, 24'h054321, 32'h80000000, 32'h7FFFFFFF, 0);
        send_item(FUNC_DERIV, 24'h054321, 32'h00000000, 32'h00000000, 0);
        finish_batch();
    endtask

    // End equal to start, then end below start
    task automatic test_empty_interval();
        write_reg(REG_AGE_BOUNDS, {16'h0000, 24'h050000, 24'h050000});
        cfg_wr_en <= 1'b0;
        send_item(FUNC_DERIV, 24'h050000, 32'h01000000, 32'h01000000, 0);
        finish_batch();
        write_reg(REG_AGE_BOUNDS, {16'hFFFF, 24'h000000, 24'hFFFFFF});
        cfg_wr_en <= 1'b0;
        send_item(FUNC_SLOPE, 24'h800000, 32'h01000000, 32'h01000000, 0);
        send_item(FUNC_NONE, 24'h000000, 32'h01000000, 32'h01000000, 0);
        finish_batch();
    endtask

    // Full-scale rates over the widest and the narrowest interval: saturation
    task automatic test_rate_extremes();
        load_config(24'h000000, 24'hFFFFFF,
                    {32'h80000000, 32'h7FFFFFFF}, {32'h7FFFFFFF, 32'h7FFFFFFF},
                    {32'h80000000, 32'h80000000}, {32'h80000000, 32'h7FFFFFFF});
        send_item(FUNC_DERIV, 24'h000000, 32'h7FFFFFFF, 32'h80000000, 0);
        send_item(FUNC_DERIV, 24'hFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0);
        send_item(FUNC_JACOB, 24'h800000, 32'h00000000, 32'h00000000, 0);
        send_item(FUNC_SLOPE, 24'h000000, 32'h01000000, 32'hFF000000, 0);
        finish_batch();
        write_reg(REG_AGE_BOUNDS, {16'h0000, 24'h123457, 24'h123456});
        cfg_wr_en <= 1'b0;
        send_item(FUNC_SLOPE, 24'h123456, 32'h01000000, 32'h01000000, 0);
        send_item(FUNC_DERIV, 24'h123457, 32'h01000000, 32'h01000000, 0);
        finish_batch();
    endtask

    // Writes past the last register must leave the configuration untouched
    task automatic test_unmapped_writes();
        for (int i = REG_OTHER + 1; i < (1 << REG_INDEX_WIDTH); i++)
            write_reg(REG_INDEX_WIDTH'(i), '1);
        cfg_wr_en <= 1'b0;
        send_item(FUNC_DERIV, 24'h123456, 32'h00800000, 32'h00400000, 0);
        send_item(FUNC_JACOB, 24'h123457, 32'h00800000, 32'h00400000, 0);
        finish_batch();
    endtask

    // Random transactions; reload the configuration every CONFIG_SPAN of them
    task automatic test_random_traffic(input int idle_pct, input int n_items);
        for (int i = 0; i < n_items; i++)
        begin
            if (i % CONFIG_SPAN == 0)
            begin
                finish_batch();
                randomize_config();
            end
            send_item(random_func(), random_age(), random_value(), random_value(),
                      pick_gap(idle_pct));
        end
        finish_batch();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        for (int k = 0; k < NUM_RATES; k++)
            cfg_rates[k] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_interval_edges();
        test_empty_interval();
        test_rate_extremes();
        test_unmapped_writes();
        test_random_traffic(0, 205);
        test_random_traffic(63, 205);
        test_random_traffic(19, 205);
        test_random_traffic(0, 205);
        test_random_traffic(63, 205);
        test_random_traffic(19, 205);

        // Let any stray result show up before the verdict
        repeat (PIPE_LATENCY + 8) @(posedge clk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* sim.f */
rtl/tsod_pkg.sv
rtl/tsod_numer.sv
rtl/tsod_div.sv
rtl/tsod_combine.sv
rtl/two_state_ode_derivative.sv
tb/two_state_ode_derivative_tb.sv
